### design/ddd_pkg.sv
// Shared types and constants for the task-graph job dispatcher.
// No dependencies; every other design file imports this package.
package ddd_pkg;

	localparam int SET_W  = 32;  // width of the queued, ready and done sets
	localparam int CNT_W  = 6;   // node count, may hold 32 itself
	localparam int ID_W   = 5;   // node and job index
	localparam int MASK_W = 32;  // dependency row

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_DONE  = 2'd2,
		OP_NONE  = 2'd3
	} ddd_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} ddd_state_t;

	typedef struct packed {
		logic            has_job;
		logic [ID_W-1:0] job_id;
		logic            last;
		logic            all_done;
		logic            bad_done;
	} ddd_res_t;

endpackage

### design/ddd_cmd_if.sv
// Command channel of the dispatcher: opcode, node and dependency mask.
// Depends on ddd_pkg for the field widths.
interface ddd_cmd_if import ddd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [ID_W-1:0]   node;
	logic [MASK_W-1:0] dep_mask;

	modport source (output valid, output opcode, output node, output dep_mask, input ready);
	modport sink   (input valid, input opcode, input node, input dep_mask, output ready);
endinterface

### design/ddd_res_if.sv
// Result channel of the dispatcher: one dispatched job or status word per beat.
// Depends on ddd_pkg for the field widths.
interface ddd_res_if import ddd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            has_job;
	logic [ID_W-1:0] job_id;
	logic            last;
	logic            all_done;
	logic            bad_done;

	modport source (output valid, output has_job, output job_id, output last,
		output all_done, output bad_done, input ready);
	modport sink   (input valid, input has_job, input job_id, input last,
		input all_done, input bad_done, output ready);
endinterface

### design/ddd_row_mem.sv
// Dependency row store: one write port and one registered read port.
// Depends on ddd_pkg for the row width.
module ddd_row_mem import ddd_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [MASK_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [MASK_W-1:0] rdata
);

	logic [MASK_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/ddd_ctrl.sv
// Command sequencer: holds the node sets, scans the row store one row a cycle
// and hands result words to the output stage. Depends on ddd_pkg and ddd_cmd_if.
module ddd_ctrl import ddd_pkg::*; #(
	parameter int MAX_NODES = 32,
	parameter int AW        = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	ddd_cmd_if.sink           cmd,
	input  logic [CNT_W-1:0]  n_use,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [MASK_W-1:0] mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [MASK_W-1:0] mem_rdata,
	output logic              emit_valid,
	output ddd_res_t          emit,
	input  logic              emit_ready
);

	ddd_state_t        state_q, state_d;
	logic [SET_W-1:0]  queued_q, ready_q, done_q, found_q;
	logic              bad_q;
	logic [CNT_W-1:0]  issue_q;
	logic              vld_s1;
	logic [ID_W-1:0]   idx_s1;

	logic [SET_W-1:0]  use_mask;
	logic              accept;
	ddd_op_t           op;
	logic [SET_W-1:0]  node_bit;
	logic              done_ok;
	logic              hit_s1;
	logic [SET_W-1:0]  lowest;
	logic [SET_W-1:0]  found_rest;
	logic [ID_W-1:0]   low_id;
	logic              scan_end;

	assign use_mask = n_use[CNT_W-1] ? {SET_W{1'b1}} : ((32'd1 << n_use[ID_W-1:0]) - 32'd1);
	assign op       = ddd_op_t'(cmd.opcode);
	assign accept   = cmd.valid && cmd.ready;
	assign node_bit = 32'd1 << cmd.node;
	assign done_ok  = ({1'b0, cmd.node} < n_use) && ((ready_q & node_bit) != '0);

	assign mem_we    = accept && (op == OP_LOAD) && (7'(cmd.node) < 7'(MAX_NODES));
	assign mem_waddr = AW'(cmd.node);
	assign mem_wdata = cmd.dep_mask;
	assign mem_raddr = AW'(issue_q);

	// A node is ready when it is still queued and every in-use dependency is done.
	assign hit_s1 = vld_s1 && queued_q[idx_s1] && ((mem_rdata & use_mask & ~done_q) == '0);
	assign scan_end = !mem_re && !vld_s1;

	assign lowest     = found_q & (~found_q + 32'd1);
	assign found_rest = found_q & ~lowest;

	always_comb begin
		low_id = '0;
		for (int i = SET_W - 1; i >= 0; i--) begin
			if (found_q[i]) begin
				low_id = ID_W'(i);
			end
		end
	end

	always_comb begin
		emit.has_job  = (found_q != '0);
		emit.job_id   = low_id;
		emit.last     = (found_rest == '0);
		emit.all_done = ((done_q & use_mask) == use_mask);
		emit.bad_done = bad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.ready  = 1'b0;
		mem_re     = 1'b0;
		emit_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (cmd.valid) begin
					if (op == OP_START || (op == OP_DONE && done_ok)) begin
						state_d = ST_SCAN;
					end else if (op == OP_DONE) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				mem_re = (issue_q < n_use);
				if (scan_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				emit_valid = 1'b1;
				if (emit_ready && emit.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q <= '0;
			ready_q  <= '0;
			done_q   <= '0;
			found_q  <= '0;
			bad_q    <= 1'b0;
			issue_q  <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
		end else begin
			vld_s1 <= mem_re;
			idx_s1 <= issue_q[ID_W-1:0];
			if (accept && op == OP_START) begin
				queued_q <= use_mask;
				ready_q  <= '0;
				done_q   <= '0;
				found_q  <= '0;
				bad_q    <= 1'b0;
				issue_q  <= '0;
			end else if (accept && op == OP_DONE) begin
				found_q <= '0;
				issue_q <= '0;
				if (done_ok) begin
					ready_q <= ready_q & ~node_bit;
					done_q  <= done_q | node_bit;
					bad_q   <= 1'b0;
				end else begin
					bad_q <= 1'b1;
				end
			end else begin
				if (mem_re) begin
					issue_q <= issue_q + CNT_W'(1);
				end
				if (hit_s1) begin
					queued_q[idx_s1] <= 1'b0;
					ready_q[idx_s1]  <= 1'b1;
					found_q[idx_s1]  <= 1'b1;
				end
				if (emit_valid && emit_ready) begin
					found_q <= found_rest;
				end
			end
		end
	end

endmodule

### design/dag_dependency_dispatcher.sv
// Top level of the task-graph job dispatcher: node count register, output
// register and the row store and sequencer. Depends on ddd_pkg, the two channel
// interfaces, ddd_row_mem and ddd_ctrl.
//
//   channel  dir  handshake      word
//   cmd      in   valid/ready    opcode, node, dep_mask
//   res      out  valid/ready    has_job, job_id, last, all_done, bad_done
//   cfg      in   cfg_we         node_count in cfg_wdata
//
// A load or an unused opcode leaves the sequencer idle. A start or a good done report
// scans the row store one row a cycle, then its words pass through the emit state
// and the output register to res, one word a cycle while res is ready.
// A bad done report's word passes through the emit state and the output register to res.
// No command is taken until the last word has entered the output register, which
// holds a stalled word. Reset clears the node sets and sets the node count to 32.
module dag_dependency_dispatcher import ddd_pkg::*; #(
	parameter int MAX_NODES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	ddd_cmd_if.sink          cmd,
	ddd_res_if.source        res,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CAP = (MAX_NODES < SET_W) ? MAX_NODES : SET_W;

	logic [CNT_W-1:0]  node_count_q;
	logic [CNT_W-1:0]  n_use;
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [MASK_W-1:0] mem_wdata, mem_rdata;
	logic              emit_valid, emit_ready;
	ddd_res_t          emit;
	ddd_res_t          res_q;
	logic              res_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(32);
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	assign n_use = (node_count_q > CNT_W'(CAP)) ? CNT_W'(CAP) : node_count_q;

	ddd_row_mem #(
		.DEPTH (MAX_NODES),
		.AW    (AW)
	) u_rows (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ddd_ctrl #(
		.MAX_NODES (MAX_NODES),
		.AW        (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.n_use      (n_use),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.emit_valid (emit_valid),
		.emit       (emit),
		.emit_ready (emit_ready)
	);

	// The output register takes a new word when empty or when its word leaves.
	assign emit_ready = !res_vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (emit_ready) begin
			res_vld_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ready && emit_valid) begin
			res_q <= emit;
		end
	end

	assign res.valid    = res_vld_q;
	assign res.has_job  = res_q.has_job;
	assign res.job_id   = res_q.job_id;
	assign res.last     = res_q.last;
	assign res.all_done = res_q.all_done;
	assign res.bad_done = res_q.bad_done;

	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.bad_done) |-> (res.last && !res.has_job))
		else $error("bad done word carries a job or is not last");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.opcode == OP_START) |=> !cmd.ready)
		else $error("command taken during a scan");

	a_nojob_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.has_job) |-> (res.last && res.job_id == '0))
		else $error("empty result word is not the last one");

endmodule
